FILE: rtl/tflm_pkg.sv
// ----------------------------------------------------------------------------
// tflm_pkg: shared types and constants of the trilinear field-map lookup
// Widths, default grid sizes, register indexes and request opcodes.
// ----------------------------------------------------------------------------
package tflm_pkg;

  // default grid shape and fraction width
  localparam int unsigned DEF_PHI_NODES = 32;
  localparam int unsigned DEF_RHO_NODES = 32;
  localparam int unsigned DEF_Z_NODES   = 64;
  localparam int unsigned DEF_FRAC_BITS = 16;

  // field and datapath widths
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned NCOMP     = 3;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned PROD_FRAC = 40;
  localparam int unsigned CFG_IDX_W = 3;

  // 1.0 in unsigned q8.24
  localparam logic [COORD_W-1:0] INV_STEP_ONE = 32'h0100_0000;

  // one node: three components, component a at index 0
  typedef logic [NCOMP-1:0][COORD_W-1:0] vec_t;

  // request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHI_ORIGIN   = 3'd0,
    REG_PHI_INV_STEP = 3'd1,
    REG_RHO_ORIGIN   = 3'd2,
    REG_RHO_INV_STEP = 3'd3,
    REG_Z_ORIGIN     = 3'd4,
    REG_Z_INV_STEP   = 3'd5
  } cfg_reg_t;

endpackage

FILE: rtl/tflm_in_if.sv
// ----------------------------------------------------------------------------
// tflm_in_if: request channel of the field-map lookup
// Valid/ready handshake carrying node writes and queries.
// ----------------------------------------------------------------------------
interface tflm_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] node_index;
  logic signed [31:0] node_comp_a;
  logic signed [31:0] node_comp_b;
  logic signed [31:0] node_comp_c;
  logic signed [31:0] q_phi;
  logic signed [31:0] q_rho;
  logic signed [31:0] q_z;

  modport source (
    output valid, op, node_index, node_comp_a, node_comp_b, node_comp_c,
           q_phi, q_rho, q_z,
    input  ready
  );

  modport sink (
    input  valid, op, node_index, node_comp_a, node_comp_b, node_comp_c,
           q_phi, q_rho, q_z,
    output ready
  );
endinterface

FILE: rtl/tflm_out_if.sv
// ----------------------------------------------------------------------------
// tflm_out_if: result channel of the field-map lookup
// Valid/ready handshake carrying one interpolated vector per query.
// ----------------------------------------------------------------------------
interface tflm_out_if;
  logic        valid;
  logic        ready;
  logic        in_range;
  logic signed [31:0] out_comp_a;
  logic signed [31:0] out_comp_b;
  logic signed [31:0] out_comp_c;

  modport source (
    output valid, in_range, out_comp_a, out_comp_b, out_comp_c,
    input  ready
  );

  modport sink (
    input  valid, in_range, out_comp_a, out_comp_b, out_comp_c,
    output ready
  );
endinterface

FILE: rtl/tflm_node_mem.sv
// ----------------------------------------------------------------------------
// tflm_node_mem: grid node storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tflm_node_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tflm_pkg::ADDR_W-1:0] waddr,
  input  tflm_pkg::vec_t             wdata,
  input  logic                       re,
  input  logic [tflm_pkg::ADDR_W-1:0] raddr,
  output tflm_pkg::vec_t             rdata
);

  tflm_pkg::vec_t mem [tflm_pkg::MEM_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tflm_blend.sv
// ----------------------------------------------------------------------------
// tflm_blend: shared three-lane linear blend unit
// res = round(a + (b - a) * t), t in unsigned 1.FRAC_BITS, ties rounded up.
// Three-stage pipeline: difference, product, add and round.
// ----------------------------------------------------------------------------
module tflm_blend #(
  parameter int unsigned FRAC_BITS = tflm_pkg::DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  tflm_pkg::vec_t       a,
  input  tflm_pkg::vec_t       b,
  input  logic [FRAC_BITS:0]   t,
  output logic                 done,
  output tflm_pkg::vec_t       res
);

  localparam int unsigned TW = FRAC_BITS + 1;
  localparam int unsigned DW = tflm_pkg::COORD_W + 1;
  localparam int unsigned PW = DW + TW + 1;
  localparam int unsigned SW = PW + 1;

  logic [2:0] vld;
  logic [tflm_pkg::NCOMP-1:0][DW-1:0] diff;
  logic [tflm_pkg::NCOMP-1:0][PW-1:0] prod;
  logic signed [SW-1:0] sum [tflm_pkg::NCOMP];
  tflm_pkg::vec_t a1;
  tflm_pkg::vec_t a2;
  logic [TW-1:0] t1;

  // stage valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], start};
    end
  end

  assign done = vld[2];

  // rounded sum per lane
  always_comb begin
    for (int i = 0; i < tflm_pkg::NCOMP; i++) begin
      sum[i] = (SW'(signed'(a2[i])) <<< FRAC_BITS) + SW'(signed'(prod[i]))
             + (SW'(1) <<< (FRAC_BITS - 1));
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    t1 <= t;
    a1 <= a;
    a2 <= a1;
    for (int i = 0; i < tflm_pkg::NCOMP; i++) begin
      diff[i] <= {b[i][tflm_pkg::COORD_W-1], b[i]} - {a[i][tflm_pkg::COORD_W-1], a[i]};
      prod[i] <= PW'($signed(diff[i]) * $signed({1'b0, t1}));
      res[i]  <= sum[i][FRAC_BITS +: tflm_pkg::COORD_W];
    end
  end

endmodule

FILE: rtl/trilinear_field_map_lookup.sv
// ----------------------------------------------------------------------------
// trilinear_field_map_lookup: 3-D grid field map with trilinear blending
// Stores three-component nodes and answers interpolated point queries.
// ----------------------------------------------------------------------------
// Usage
//   req channel: op = write loads one node (node_index, node_comp_a/b/c) and
//   gives no result; op = query maps q_phi, q_rho, q_z onto the grid and
//   gives one result on the rsp channel (in_range and three components).
//   cfg port: cfg_we with cfg_index selects origin / inverse step registers;
//   write only while no query is in flight.
// Operation
//   a node write is taken while idle and leaves the block idle, so writes
//   stream back to back. A query shows its result in the same cycle as the
//   block turns ready for the next request. In range, it runs axis mapping
//   in S_MAP on one 32x32 multiplier, address in S_BASE0 and S_BASE1, then 8
//   corner reads (S_READ, S_LOAD) on the single memory read port and 7 blends
//   on the shared blend unit, then S_OUT. A query out of range goes from
//   S_MAP straight to S_OUT.
// Reset and stall
//   reset sets the registers to origin 0 and step 1.0; node memory is not
//   cleared and a node must be written before a query reads it. While the
//   receiver stalls, a finished result waits in the output register; the
//   next request is still taken, and a following query waits at its end.
// ----------------------------------------------------------------------------
module trilinear_field_map_lookup #(
  parameter int unsigned PHI_NODES = tflm_pkg::DEF_PHI_NODES,
  parameter int unsigned RHO_NODES = tflm_pkg::DEF_RHO_NODES,
  parameter int unsigned Z_NODES   = tflm_pkg::DEF_Z_NODES,
  parameter int unsigned FRAC_BITS = tflm_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tflm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tflm_pkg::COORD_W-1:0]  cfg_data,
  tflm_in_if.sink                       req,
  tflm_out_if.source                    rsp
);

  localparam int unsigned CW = tflm_pkg::COORD_W;
  localparam int unsigned AW = tflm_pkg::ADDR_W;
  localparam int unsigned IW = tflm_pkg::PROD_W - tflm_pkg::PROD_FRAC;
  localparam int unsigned TW = FRAC_BITS + 1;
  localparam int unsigned N_PR  = (PHI_NODES > RHO_NODES) ? PHI_NODES : RHO_NODES;
  localparam int unsigned N_MAX = (N_PR > Z_NODES) ? N_PR : Z_NODES;
  localparam int unsigned IDX_W = (N_MAX > 2) ? $clog2(N_MAX) : 1;

  localparam logic [IW-1:0] NM1_P = IW'(PHI_NODES - 1);
  localparam logic [IW-1:0] NM1_R = IW'(RHO_NODES - 1);
  localparam logic [IW-1:0] NM1_Z = IW'(Z_NODES - 1);

  // address strides to the upper corner, zero on a single-node axis
  localparam logic [AW-1:0] STRIDE_P = AW'((PHI_NODES > 1) ? RHO_NODES * Z_NODES : 0);
  localparam logic [AW-1:0] STRIDE_R = AW'((RHO_NODES > 1) ? Z_NODES : 0);
  localparam logic [AW-1:0] STRIDE_Z = AW'((Z_NODES > 1) ? 1 : 0);

  localparam int AX_P = 0;
  localparam int AX_R = 1;
  localparam int AX_Z = 2;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MAP   = 8'b0000_0010,
    S_BASE0 = 8'b0000_0100,
    S_BASE1 = 8'b0000_1000,
    S_READ  = 8'b0001_0000,
    S_LOAD  = 8'b0010_0000,
    S_BLEND = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    LV_Z = 2'd0,
    LV_R = 2'd1,
    LV_P = 2'd2
  } level_t;

  state_t state;
  level_t lvl;
  logic [1:0] cnt;
  logic [2:0] k;

  // configuration registers
  logic [CW-1:0] phi_origin, phi_inv_step;
  logic [CW-1:0] rho_origin, rho_inv_step;
  logic [CW-1:0] z_origin, z_inv_step;

  // axis state
  logic [2:0]            dneg;
  logic [CW-1:0]         dmag  [3];
  logic [2:0]            ok_r;
  logic [IDX_W-1:0]      idx_r [3];
  logic [TW-1:0]         tf_r  [3];
  logic [tflm_pkg::PROD_W-1:0] prod;

  // datapath registers
  logic [AW-1:0]  base_pr, base;
  tflm_pkg::vec_t hold_z, hold_r, hold_p, res_vec;
  logic           res_ok;
  logic           rsp_valid, rsp_in_range;
  tflm_pkg::vec_t rsp_comp;

  // combinational
  logic           accept, do_write, do_query, out_load;
  logic signed [CW:0] d_p, d_r, d_z;
  logic [CW-1:0]  mul_a, mul_b;
  logic [tflm_pkg::PROD_W-1:0] mul_p;
  logic [1:0]     ev_axis;
  logic [IW-1:0]  ev_nm1, prod_int;
  logic [tflm_pkg::PROD_FRAC-1:0] prod_frac;
  logic           ev_single, ev_neg, ev_inv_nz, ev_over, ev_clamp, ev_ok, all_ok;
  logic [IDX_W-1:0] ev_idx;
  logic [TW-1:0]  ev_t;
  logic [AW-1:0]  raddr;
  tflm_pkg::vec_t mem_rdata, wdata, bl_a, bl_b, bl_res;
  logic [TW-1:0]  bl_t;
  logic           bl_start, bl_done;

  // handshake decode
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign do_write  = accept && (req.op == tflm_pkg::OP_WRITE);
  assign do_query  = accept && (req.op == tflm_pkg::OP_QUERY);
  assign out_load  = (state == S_OUT) && (!rsp_valid || rsp.ready);

  // offsets from the grid origin
  assign d_p = {req.q_phi[CW-1], req.q_phi} - {phi_origin[CW-1], phi_origin};
  assign d_r = {req.q_rho[CW-1], req.q_rho} - {rho_origin[CW-1], rho_origin};
  assign d_z = {req.q_z[CW-1], req.q_z} - {z_origin[CW-1], z_origin};

  // shared axis multiplier operands
  always_comb begin
    case (cnt)
      2'd0: begin mul_a = dmag[AX_P]; mul_b = phi_inv_step; end
      2'd1: begin mul_a = dmag[AX_R]; mul_b = rho_inv_step; end
      2'd2: begin mul_a = dmag[AX_Z]; mul_b = z_inv_step; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // axis evaluation of the previous product
  always_comb begin
    ev_axis = cnt - 2'd1;
    case (cnt)
      2'd1: begin
        ev_nm1 = NM1_P; ev_single = (PHI_NODES == 1);
        ev_neg = dneg[AX_P]; ev_inv_nz = |phi_inv_step;
      end
      2'd2: begin
        ev_nm1 = NM1_R; ev_single = (RHO_NODES == 1);
        ev_neg = dneg[AX_R]; ev_inv_nz = |rho_inv_step;
      end
      2'd3: begin
        ev_nm1 = NM1_Z; ev_single = (Z_NODES == 1);
        ev_neg = dneg[AX_Z]; ev_inv_nz = |z_inv_step;
      end
      default: begin
        ev_nm1 = '0; ev_single = 1'b1; ev_neg = 1'b0; ev_inv_nz = 1'b0;
      end
    endcase
    prod_int  = prod[tflm_pkg::PROD_W-1:tflm_pkg::PROD_FRAC];
    prod_frac = prod[tflm_pkg::PROD_FRAC-1:0];
    ev_over   = (prod_int > ev_nm1) || ((prod_int == ev_nm1) && (prod_frac != '0));
    ev_clamp  = (prod_int >= ev_nm1);
    ev_ok     = ev_single || (!(ev_neg && ev_inv_nz) && !ev_over);
    if (ev_single) begin
      ev_idx = '0;
      ev_t   = '0;
    end else if (ev_clamp) begin
      ev_idx = IDX_W'(ev_nm1 - IW'(1));
      ev_t   = TW'(1) << FRAC_BITS;
    end else begin
      ev_idx = prod_int[IDX_W-1:0];
      ev_t   = {1'b0, prod_frac[tflm_pkg::PROD_FRAC-1 -: FRAC_BITS]};
    end
  end

  assign all_ok = ok_r[AX_P] && ok_r[AX_R] && ev_ok;

  // corner address: bit 2 phi, bit 1 rho, bit 0 z
  assign raddr = base + (k[2] ? STRIDE_P : '0) + (k[1] ? STRIDE_R : '0)
               + (k[0] ? STRIDE_Z : '0);

  // blend operand select
  always_comb begin
    if (state == S_LOAD) begin
      bl_a = hold_z; bl_b = mem_rdata; bl_t = tf_r[AX_Z];
    end else if (lvl == LV_Z) begin
      bl_a = hold_r; bl_b = bl_res; bl_t = tf_r[AX_R];
    end else begin
      bl_a = hold_p; bl_b = bl_res; bl_t = tf_r[AX_P];
    end
  end

  assign bl_start = ((state == S_LOAD) && k[0])
                 || ((state == S_BLEND) && bl_done
                     && (((lvl == LV_Z) && k[1]) || ((lvl == LV_R) && k[2])));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      phi_origin   <= '0;
      rho_origin   <= '0;
      z_origin     <= '0;
      phi_inv_step <= tflm_pkg::INV_STEP_ONE;
      rho_inv_step <= tflm_pkg::INV_STEP_ONE;
      z_inv_step   <= tflm_pkg::INV_STEP_ONE;
    end else if (cfg_we) begin
      case (tflm_pkg::cfg_reg_t'(cfg_index))
        tflm_pkg::REG_PHI_ORIGIN:   phi_origin   <= cfg_data;
        tflm_pkg::REG_PHI_INV_STEP: phi_inv_step <= cfg_data;
        tflm_pkg::REG_RHO_ORIGIN:   rho_origin   <= cfg_data;
        tflm_pkg::REG_RHO_INV_STEP: rho_inv_step <= cfg_data;
        tflm_pkg::REG_Z_ORIGIN:     z_origin     <= cfg_data;
        tflm_pkg::REG_Z_INV_STEP:   z_inv_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lvl       <= LV_Z;
      cnt       <= '0;
      k         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // result register: loaded from the output state, cleared when taken
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (do_query) begin
            cnt   <= '0;
            state <= S_MAP;
          end
        end
        S_MAP: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= all_ok ? S_BASE0 : S_OUT;
          end
        end
        S_BASE0: state <= S_BASE1;
        S_BASE1: begin
          k     <= '0;
          state <= S_READ;
        end
        S_READ: state <= S_LOAD;
        S_LOAD: begin
          if (!k[0]) begin
            k     <= k + 3'd1;
            state <= S_READ;
          end else begin
            lvl   <= LV_Z;
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          if (bl_done) begin
            case (lvl)
              LV_Z: begin
                if (!k[1]) begin
                  k     <= k + 3'd1;
                  state <= S_READ;
                end else begin
                  lvl <= LV_R;
                end
              end
              LV_R: begin
                if (!k[2]) begin
                  k     <= k + 3'd1;
                  state <= S_READ;
                end else begin
                  lvl <= LV_P;
                end
              end
              LV_P: state <= S_OUT;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (do_query) begin
      dneg       <= {d_z[CW], d_r[CW], d_p[CW]};
      dmag[AX_P] <= d_p[CW] ? '0 : d_p[CW-1:0];
      dmag[AX_R] <= d_r[CW] ? '0 : d_r[CW-1:0];
      dmag[AX_Z] <= d_z[CW] ? '0 : d_z[CW-1:0];
    end
    if (state == S_MAP) begin
      prod <= mul_p;
      if (cnt != 2'd0) begin
        ok_r[ev_axis]  <= ev_ok;
        idx_r[ev_axis] <= ev_idx;
        tf_r[ev_axis]  <= ev_t;
      end
      if (cnt == 2'd3) begin
        res_ok <= all_ok;
      end
    end
    if (state == S_BASE0) begin
      base_pr <= AW'(AW'(idx_r[AX_P]) * AW'(RHO_NODES) + AW'(idx_r[AX_R]));
    end
    if (state == S_BASE1) begin
      base <= AW'(base_pr * AW'(Z_NODES) + AW'(idx_r[AX_Z]));
    end
    if ((state == S_LOAD) && !k[0]) begin
      hold_z <= mem_rdata;
    end
    if ((state == S_BLEND) && bl_done) begin
      if ((lvl == LV_Z) && !k[1]) begin
        hold_r <= bl_res;
      end
      if ((lvl == LV_R) && !k[2]) begin
        hold_p <= bl_res;
      end
      if (lvl == LV_P) begin
        res_vec <= bl_res;
      end
    end
    if (out_load) begin
      rsp_in_range <= res_ok;
      rsp_comp     <= res_ok ? res_vec : '0;
    end
  end

  // node write data
  assign wdata[0] = req.node_comp_a;
  assign wdata[1] = req.node_comp_b;
  assign wdata[2] = req.node_comp_c;

  tflm_node_mem u_mem (
    .clk   (clk),
    .we    (do_write),
    .waddr (req.node_index),
    .wdata (wdata),
    .re    (state == S_READ),
    .raddr (raddr),
    .rdata (mem_rdata)
  );

  tflm_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk   (clk),
    .rst   (rst),
    .start (bl_start),
    .a     (bl_a),
    .b     (bl_b),
    .t     (bl_t),
    .done  (bl_done),
    .res   (bl_res)
  );

  // result channel
  assign rsp.valid      = rsp_valid;
  assign rsp.in_range   = rsp_in_range;
  assign rsp.out_comp_a = rsp_comp[0];
  assign rsp.out_comp_b = rsp_comp[1];
  assign rsp.out_comp_c = rsp_comp[2];

endmodule

FILE: rtl/tflm_check.sv
// ----------------------------------------------------------------------------
// tflm_check: port-level checks of the field-map lookup
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module tflm_check (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_op,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_in_range,
  input logic [31:0] rsp_comp_a,
  input logic [31:0] rsp_comp_b,
  input logic [31:0] rsp_comp_c
);

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // a point outside the grid gives zero components
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_in_range |-> (rsp_comp_a == '0) && (rsp_comp_b == '0)
                                   && (rsp_comp_c == '0))
    else $error("nonzero components on out-of-range result");

  // a query keeps the block busy for the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_op == tflm_pkg::OP_QUERY) |=> !req_ready)
    else $error("request taken right after a query");

  // after reset the block is idle with no result
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid && req_ready)
    else $error("not idle after reset");

endmodule

bind trilinear_field_map_lookup tflm_check u_check (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_op       (req.op),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_in_range (rsp.in_range),
  .rsp_comp_a   (rsp.out_comp_a),
  .rsp_comp_b   (rsp.out_comp_b),
  .rsp_comp_c   (rsp.out_comp_c)
);

FILE: sim/trilinear_field_map_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_field_map_lookup_tb: self-checking bench for the field-map lookup
// Loads grid nodes and sends point queries over several origin and step
// settings. Every result is checked against a local trilinear predictor.
// Both handshakes see random bursts of idle and stall cycles.
// ----------------------------------------------------------------------------
module trilinear_field_map_lookup_tb;

  localparam int unsigned PHI_N = tflm_pkg::DEF_PHI_NODES;
  localparam int unsigned RHO_N = tflm_pkg::DEF_RHO_NODES;
  localparam int unsigned Z_N   = tflm_pkg::DEF_Z_NODES;
  localparam int unsigned FRAC_N = tflm_pkg::DEF_FRAC_BITS;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam logic [31:0] LAST_PHI = 32'((PHI_N - 1) << 16);
  localparam logic [31:0] LAST_RHO = 32'((RHO_N - 1) << 16);
  localparam logic [31:0] LAST_Z   = 32'((Z_N - 1) << 16);

  typedef struct {
    logic           op;
    logic [15:0]    node_index;
    tflm_pkg::vec_t node;
    logic [31:0]    q_phi;
    logic [31:0]    q_rho;
    logic [31:0]    q_z;
  } req_item_t;

  typedef struct packed {
    logic           in_range;
    tflm_pkg::vec_t comp;
  } field_t;

  typedef struct {
    bit          ok;
    int unsigned lo;
    int unsigned hi;
    longint      t;
  } axis_span_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [tflm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tflm_pkg::COORD_W-1:0] cfg_data;

  tflm_in_if  req_bus ();
  tflm_out_if rsp_bus ();

  // local copy of the registers and the node memory
  logic [31:0] grid_reg [6];
  tflm_pkg::vec_t node_store [tflm_pkg::MEM_DEPTH];
  bit   node_seen [tflm_pkg::MEM_DEPTH];
  field_t pending_fields [$];

  bit req_gaps_on;
  bit rsp_stalls_on;
  bit quiet_mode;
  int unsigned stall_left;
  int unsigned cycles;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned n_writes, n_queries, n_inside, n_outside, n_settings, n_checked;

  trilinear_field_map_lookup #(
    .PHI_NODES(PHI_N),
    .RHO_NODES(RHO_N),
    .Z_NODES(Z_N),
    .FRAC_BITS(FRAC_N)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] node_addr(int unsigned p, int unsigned r, int unsigned z);
    return 16'((p * RHO_N + r) * Z_N + z);
  endfunction

  // place one coordinate on its axis: box index and fraction
  function automatic axis_span_t map_axis(logic [31:0] q, logic [31:0] origin,
                                          logic [31:0] inv, int unsigned n);
    axis_span_t s;
    longint d;
    logic [63:0] prod;
    logic [63:0] top;
    longint unsigned i;
    s.ok = 1'b1;
    s.lo = 0;
    s.hi = 0;
    s.t  = 0;
    if (n <= 1) return s;
    d = longint'($signed(q)) - longint'($signed(origin));
    if (inv != 0 && d < 0) begin
      s.ok = 1'b0;
      return s;
    end
    prod = (d < 0) ? 64'd0 : $unsigned(d) * {32'd0, inv};
    top = 64'(n - 1) << tflm_pkg::PROD_FRAC;
    if (prod > top) begin
      s.ok = 1'b0;
      return s;
    end
    i = prod >> tflm_pkg::PROD_FRAC;
    if (i > n - 2) i = n - 2;
    s.lo = 32'(i);
    s.hi = 32'(i + 1);
    s.t  = longint'((prod - (64'(i) << tflm_pkg::PROD_FRAC))
                    >> (tflm_pkg::PROD_FRAC - FRAC_N));
    return s;
  endfunction

  // linear blend, round to nearest with ties up
  function automatic longint lerp_q(longint a, longint b, longint t);
    longint acc;
    acc = a * ((longint'(1) << FRAC_N) - t) + b * t;
    return (acc + (longint'(1) << (FRAC_N - 1))) >>> FRAC_N;
  endfunction

  function automatic longint node_comp(int unsigned p, int unsigned r, int unsigned z, int k);
    return longint'($signed(node_store[node_addr(p, r, z)][k]));
  endfunction

  // z first, then rho, then phi
  function automatic field_t interp_field(logic [31:0] qp, logic [31:0] qr, logic [31:0] qz);
    axis_span_t ap, ar, az;
    field_t f;
    longint c00, c01, c10, c11, c0, c1, cf;
    int k;
    ap = map_axis(qp, grid_reg[tflm_pkg::REG_PHI_ORIGIN],
                  grid_reg[tflm_pkg::REG_PHI_INV_STEP], PHI_N);
    ar = map_axis(qr, grid_reg[tflm_pkg::REG_RHO_ORIGIN],
                  grid_reg[tflm_pkg::REG_RHO_INV_STEP], RHO_N);
    az = map_axis(qz, grid_reg[tflm_pkg::REG_Z_ORIGIN],
                  grid_reg[tflm_pkg::REG_Z_INV_STEP], Z_N);
    f = '0;
    if (!(ap.ok && ar.ok && az.ok)) return f;
    f.in_range = 1'b1;
    for (k = 0; k < tflm_pkg::NCOMP; k++) begin
      c00 = lerp_q(node_comp(ap.lo, ar.lo, az.lo, k), node_comp(ap.lo, ar.lo, az.hi, k), az.t);
      c01 = lerp_q(node_comp(ap.lo, ar.hi, az.lo, k), node_comp(ap.lo, ar.hi, az.hi, k), az.t);
      c10 = lerp_q(node_comp(ap.hi, ar.lo, az.lo, k), node_comp(ap.hi, ar.lo, az.hi, k), az.t);
      c11 = lerp_q(node_comp(ap.hi, ar.hi, az.lo, k), node_comp(ap.hi, ar.hi, az.hi, k), az.t);
      c0 = lerp_q(c00, c01, ar.t);
      c1 = lerp_q(c10, c11, ar.t);
      cf = lerp_q(c0, c1, ap.t);
      f.comp[k] = cf[31:0];
    end
    return f;
  endfunction

  // update the local state for a request taken by the block
  function automatic void absorb_item(req_item_t it);
    field_t f;
    items_sent++;
    if (it.op == tflm_pkg::OP_WRITE) begin
      node_store[it.node_index] = it.node;
      node_seen[it.node_index] = 1'b1;
      n_writes++;
    end else begin
      f = interp_field(it.q_phi, it.q_rho, it.q_z);
      pending_fields = {pending_fields, f};
      n_queries++;
      if (f.in_range) n_inside++;
      else n_outside++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic tflm_pkg::vec_t rand_vec();
    tflm_pkg::vec_t v;
    int k;
    for (k = 0; k < tflm_pkg::NCOMP; k++) begin
      case ($urandom_range(0, 5))
        0: v[k] = 32'h7FFF_FFFF;
        1: v[k] = 32'h8000_0000;
        2: v[k] = 32'($urandom_range(0, 2000)) - 32'd1000;
        default: v[k] = $urandom;
      endcase
    end
    return v;
  endfunction

  function automatic int unsigned pick_slot(int unsigned n);
    return (n > 1) ? $urandom_range(0, n - 2) : 0;
  endfunction

  // coordinate that should land in a given box; the axis origin when out of reach
  function automatic logic [31:0] coord_for(logic [31:0] origin, logic [31:0] inv,
                                            int unsigned n, int unsigned slot);
    longint unsigned f40;
    longint unsigned d;
    longint q;
    if (inv == 0) return $urandom;
    f40 = 64'(slot) << tflm_pkg::PROD_FRAC;
    if (slot < n - 1 && $urandom_range(0, 7) != 0)
      f40 = f40 | ({32'($urandom), 32'($urandom)} & ((64'd1 << tflm_pkg::PROD_FRAC) - 1));
    d = f40 / inv;
    q = longint'($signed(origin)) + longint'(d);
    if (q > Q_MAX || q < Q_MIN) return origin;
    return q[31:0];
  endfunction

  function automatic logic [31:0] rand_origin();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1, 2, 3: return tflm_pkg::INV_STEP_ONE << $urandom_range(0, 4);
      4: return tflm_pkg::INV_STEP_ONE >> $urandom_range(1, 8);
      default: return $urandom_range(32'h0010_0000, 32'h1000_0000);
    endcase
  endfunction

  // one request over the channel; valid stays up for a following request
  task automatic send_item(input req_item_t it);
    if (req_gaps_on && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.op          <= it.op;
    req_bus.node_index  <= it.node_index;
    req_bus.node_comp_a <= it.node[0];
    req_bus.node_comp_b <= it.node[1];
    req_bus.node_comp_c <= it.node[2];
    req_bus.q_phi       <= it.q_phi;
    req_bus.q_rho       <= it.q_rho;
    req_bus.q_z         <= it.q_z;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    absorb_item(it);
  endtask

  task automatic send_write(input logic [15:0] addr, input tflm_pkg::vec_t v);
    req_item_t it;
    it.op = tflm_pkg::OP_WRITE;
    it.node_index = addr;
    it.node = v;
    it.q_phi = $urandom;
    it.q_rho = $urandom;
    it.q_z = $urandom;
    send_item(it);
  endtask

  // query; corner nodes not yet loaded are written first
  task automatic send_query(input logic [31:0] qp, input logic [31:0] qr,
                            input logic [31:0] qz);
    req_item_t it;
    axis_span_t ap, ar, az;
    logic [15:0] a;
    int k;
    ap = map_axis(qp, grid_reg[tflm_pkg::REG_PHI_ORIGIN],
                  grid_reg[tflm_pkg::REG_PHI_INV_STEP], PHI_N);
    ar = map_axis(qr, grid_reg[tflm_pkg::REG_RHO_ORIGIN],
                  grid_reg[tflm_pkg::REG_RHO_INV_STEP], RHO_N);
    az = map_axis(qz, grid_reg[tflm_pkg::REG_Z_ORIGIN],
                  grid_reg[tflm_pkg::REG_Z_INV_STEP], Z_N);
    if (ap.ok && ar.ok && az.ok) begin
      for (k = 0; k < 8; k++) begin
        a = node_addr(k[2] ? ap.hi : ap.lo, k[1] ? ar.hi : ar.lo, k[0] ? az.hi : az.lo);
        if (!node_seen[a]) send_write(a, rand_vec());
      end
    end
    it.op = tflm_pkg::OP_QUERY;
    it.node_index = $urandom;
    it.node[0] = $urandom;
    it.node[1] = $urandom;
    it.node[2] = $urandom;
    it.q_phi = qp;
    it.q_rho = qr;
    it.q_z = qz;
    send_item(it);
  endtask

  task automatic query_box(input int unsigned p, input int unsigned r, input int unsigned z);
    send_query(coord_for(grid_reg[tflm_pkg::REG_PHI_ORIGIN],
                         grid_reg[tflm_pkg::REG_PHI_INV_STEP], PHI_N, p),
               coord_for(grid_reg[tflm_pkg::REG_RHO_ORIGIN],
                         grid_reg[tflm_pkg::REG_RHO_INV_STEP], RHO_N, r),
               coord_for(grid_reg[tflm_pkg::REG_Z_ORIGIN],
                         grid_reg[tflm_pkg::REG_Z_INV_STEP], Z_N, z));
  endtask

  // stop sending, wait for every result, then let the pipeline settle
  task automatic quiesce();
    req_bus.valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all six registers; only called with the block idle
  task automatic program_grid(input logic [31:0] po, input logic [31:0] ps,
                              input logic [31:0] ro, input logic [31:0] rs,
                              input logic [31:0] zo, input logic [31:0] zs);
    logic [31:0] setting [6];
    tflm_pkg::cfg_reg_t r;
    setting[tflm_pkg::REG_PHI_ORIGIN]   = po;
    setting[tflm_pkg::REG_PHI_INV_STEP] = ps;
    setting[tflm_pkg::REG_RHO_ORIGIN]   = ro;
    setting[tflm_pkg::REG_RHO_INV_STEP] = rs;
    setting[tflm_pkg::REG_Z_ORIGIN]     = zo;
    setting[tflm_pkg::REG_Z_INV_STEP]   = zs;
    r = tflm_pkg::REG_PHI_ORIGIN;
    repeat (r.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_data  <= setting[r];
      @(posedge clk);
      grid_reg[r] = setting[r];
      r = r.next();
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // mixed traffic: mostly loaded boxes followed by queries into them
  task automatic run_traffic(input int unsigned budget);
    int unsigned stop_at, hold_at, p, r, z, pick;
    stop_at = items_sent + budget;
    hold_at = items_sent + $urandom_range(budget / 4, 3 * budget / 4);
    while (items_sent < stop_at) begin
      if (items_sent >= hold_at) begin
        quiesce();
        hold_at = stop_at + 1;
      end
      if (!quiet_mode && $urandom_range(0, 63) == 0) begin
        req_gaps_on   = $urandom_range(0, 2) != 0;
        rsp_stalls_on = $urandom_range(0, 2) != 0;
      end
      pick = $urandom_range(0, 19);
      p = pick_slot(PHI_N);
      r = pick_slot(RHO_N);
      z = pick_slot(Z_N);
      if (pick < 11) begin
        // load one box, then a few queries inside it
        for (int k = 0; k < 8; k++)
          send_write(node_addr(p + k[2], r + k[1], z + k[0]), rand_vec());
        repeat ($urandom_range(1, 4)) query_box(p, r, z);
      end else if (pick < 15) begin
        query_box($urandom_range(0, PHI_N - 1), $urandom_range(0, RHO_N - 1),
                  $urandom_range(0, Z_N - 1));
      end else if (pick < 17) begin
        send_write(16'($urandom), rand_vec());
      end else begin
        send_query($urandom, $urandom, $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // unit grid: extremes, ties, last node, points just outside
  task automatic test_corner_cases();
    tflm_pkg::vec_t v;
    int k;
    program_grid(32'd0, tflm_pkg::INV_STEP_ONE, 32'd0, tflm_pkg::INV_STEP_ONE,
                 32'd0, tflm_pkg::INV_STEP_ONE);
    for (k = 0; k < 8; k++) begin
      v[0] = (k[2] ^ k[1] ^ k[0]) ? 32'h7FFF_FFFF : 32'h8000_0000;
      v[1] = k[0] ? 32'd1 : 32'd0;
      v[2] = k[0] ? 32'hFFFF_FFFF : 32'd0;
      send_write(node_addr(k[2], k[1], k[0]), v);
    end
    send_query(32'd0, 32'd0, 32'd0);
    send_query(32'h8000, 32'h8000, 32'h8000);
    send_query(32'd0, 32'd0, 32'h8000);
    send_query({16'd0, 16'($urandom)}, {16'd0, 16'($urandom)}, {16'd0, 16'($urandom)});
    send_query(LAST_PHI, LAST_RHO, LAST_Z);
    send_query(LAST_PHI, LAST_RHO, LAST_Z + 32'd1);
    send_query(32'hFFFF_FFFF, 32'd0, 32'd0);
    send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    send_write(16'hFFFF, rand_vec());
    send_query(LAST_PHI, LAST_RHO, LAST_Z);
    quiesce();
  endtask

  task automatic test_unit_grid();
    run_traffic(250);
    quiesce();
  endtask

  task automatic test_scaled_grid();
    program_grid(rand_origin(), tflm_pkg::INV_STEP_ONE << 2,
                 rand_origin(), tflm_pkg::INV_STEP_ONE >> 2,
                 rand_origin(), $urandom_range(32'h0080_0000, 32'h0800_0000));
    run_traffic(250);
    quiesce();
  endtask

  // zero step pins an axis to its first box; the smallest step nearly so
  task automatic test_zero_step();
    program_grid($urandom, 32'd0, 32'd0, 32'd1, rand_origin(), tflm_pkg::INV_STEP_ONE);
    run_traffic(150);
    quiesce();
  endtask

  task automatic test_extreme_grid();
    program_grid(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, tflm_pkg::INV_STEP_ONE,
                 32'h8000_0000, tflm_pkg::INV_STEP_ONE);
    run_traffic(100);
    quiesce();
    program_grid(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd1, 32'd0, 32'hFFFF_FFFF);
    run_traffic(100);
    quiesce();
  endtask

  task automatic test_random_grids();
    repeat (4) begin
      program_grid(rand_origin(), rand_step(), rand_origin(), rand_step(),
                   rand_origin(), rand_step());
      run_traffic(100);
      quiesce();
    end
  endtask

  // back to back at full rate, no random gaps or stalls on either side
  task automatic test_full_rate();
    quiet_mode    = 1'b1;
    req_gaps_on   = 1'b0;
    rsp_stalls_on = 1'b0;
    program_grid(rand_origin(), tflm_pkg::INV_STEP_ONE, rand_origin(), rand_step(),
                 rand_origin(), rand_step());
    run_traffic(250);
    quiesce();
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, checking and timeout
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      rsp_bus.ready <= 1'b0;
    end else if (rsp_stalls_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 18);
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  task automatic note_diff(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    field_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, CYCLE_LIMIT, pending_fields.size());
      $display("** trilinear_field_map_lookup: FAILED **");
      $finish;
    end else if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_fields.size() == 0) begin
        errors++;
        $display("%0t: result with no query outstanding, in_range %b a %h b %h c %h",
                 $time, rsp_bus.in_range, rsp_bus.out_comp_a, rsp_bus.out_comp_b,
                 rsp_bus.out_comp_c);
      end else begin
        want = pending_fields.pop_front();
        n_checked++;
        note_diff("in_range", 32'(want.in_range), 32'(rsp_bus.in_range));
        note_diff("out_comp_a", want.comp[0], rsp_bus.out_comp_a);
        note_diff("out_comp_b", want.comp[1], rsp_bus.out_comp_b);
        note_diff("out_comp_c", want.comp[2], rsp_bus.out_comp_c);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = tflm_pkg::REG_PHI_ORIGIN;
    cfg_data = '0;
    req_bus.valid = 1'b0;
    req_bus.op = tflm_pkg::OP_WRITE;
    req_bus.node_index = '0;
    req_bus.node_comp_a = '0;
    req_bus.node_comp_b = '0;
    req_bus.node_comp_c = '0;
    req_bus.q_phi = '0;
    req_bus.q_rho = '0;
    req_bus.q_z = '0;
    req_gaps_on = 1'b1;
    rsp_stalls_on = 1'b1;
    quiet_mode = 1'b0;
    grid_reg[tflm_pkg::REG_PHI_ORIGIN]   = '0;
    grid_reg[tflm_pkg::REG_PHI_INV_STEP] = tflm_pkg::INV_STEP_ONE;
    grid_reg[tflm_pkg::REG_RHO_ORIGIN]   = '0;
    grid_reg[tflm_pkg::REG_RHO_INV_STEP] = tflm_pkg::INV_STEP_ONE;
    grid_reg[tflm_pkg::REG_Z_ORIGIN]     = '0;
    grid_reg[tflm_pkg::REG_Z_INV_STEP]   = tflm_pkg::INV_STEP_ONE;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_cases();
    test_unit_grid();
    test_scaled_grid();
    test_zero_step();
    test_extreme_grid();
    test_random_grids();
    test_full_rate();

    if (pending_fields.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_fields.size());
    end
    $display("covered %0d node writes and %0d queries (%0d inside the grid, %0d outside)",
             n_writes, n_queries, n_inside, n_outside);
    $display("over %0d register settings, %0d results checked, %0d mismatches",
             n_settings, n_checked, errors);
    if (errors == 0) begin
      $display("** trilinear_field_map_lookup: PASSED **");
    end else begin
      $display("** trilinear_field_map_lookup: FAILED **");
    end
    $finish;
  end

endmodule
